// ===== hdl/selbc_pkg.sv =====
// Shared constants, codes and types of the security event log blacklist check.
// Used by the top level, the port checker and the testbench.
package selbc_pkg;

   // Log geometry
   localparam int LOG_DEPTH  = 1024;
   localparam int ADDR_WIDTH = 32;
   localparam int IDX_W      = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LOG_DEPTH + 1);

   // Port field widths
   localparam int PORT_ADDR_W = 32;
   localparam int KIND_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int OUT_CNT_W   = 11;
   localparam int THRESH_W    = 11;

   localparam int SAT_W    = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
   localparam int KEY_EXT  = (ADDR_WIDTH > PORT_ADDR_W) ? ADDR_WIDTH : PORT_ADDR_W;
   localparam int COUNT_MAX = (1 << OUT_CNT_W) - 1;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(5);

   // Event kinds
   localparam logic [KIND_W-1:0] EV_NONE      = 3'd0;
   localparam logic [KIND_W-1:0] EV_VIOLATION = 3'd1;
   localparam logic [KIND_W-1:0] EV_INTRUSION = 3'd2;
   localparam logic [KIND_W-1:0] EV_ANOMALY   = 3'd3;
   localparam logic [KIND_W-1:0] EV_OTHER     = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_THRESHOLD = 2'd2;

   // Mode codes
   localparam logic MODE_LOG   = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   typedef struct packed {
      logic                  viol;
      logic [ADDR_WIDTH-1:0] dst;
      logic [ADDR_WIDTH-1:0] src;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Low ADDR_WIDTH bits of a port address, zero extended if the key is wider
   function automatic logic [ADDR_WIDTH-1:0] to_key(input logic [PORT_ADDR_W-1:0] a);
      logic [KEY_EXT-1:0] ext;
      ext = KEY_EXT'(a);
      return ext[ADDR_WIDTH-1:0];
   endfunction

   // Clamp a count to the 11-bit result field
   function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
      logic [SAT_W-1:0] ext;
      ext = SAT_W'(v);
      if (ext > SAT_W'(COUNT_MAX)) begin
         return OUT_CNT_W'(COUNT_MAX);
      end
      return ext[OUT_CNT_W-1:0];
   endfunction

endpackage

// ===== hdl/selbc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module selbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/security_event_log_blacklist_check.sv =====
// Top level of the security event log blacklist check.
// Depends on selbc_pkg and selbc_ram (the event log memory).
//
//  channel | ports                          | direction | beat accepted when
//  --------+--------------------------------+-----------+------------------------------
//  req     | mode, local/remote addr, kind  | in        | req_valid & !req_stall
//  rsp     | status, match, close, total    | out       | rsp_valid & !rsp_stall
//  csr     | violation threshold (11 bits)  | in        | csr_wr_en
//
// Sequence: a log mode beat fetches the entry it will overwrite at acceptance, writes
// the new entry in the append state, then scans every valid entry, the one it appends
// included, through the single read port, and passes the drain and finish states. A
// check beat scans, drains and finishes; a log beat of kind none or a check of an empty
// log goes straight to the finish state. The next request is taken once the result has
// loaded and the block is back in idle.
// Reset: synchronous, active high; clears pointer, fill count, violation total,
// threshold (to 5) and the handshakes. The log memory itself is not cleared.
// Stalls: the result register holds a finished beat under rsp_stall while the
// next request beat is already taken; that beat waits in its finish cycle.
module security_event_log_blacklist_check (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [selbc_pkg::PORT_ADDR_W-1:0]    req_local_addr,
   input  logic [selbc_pkg::PORT_ADDR_W-1:0]    req_remote_addr,
   input  logic [selbc_pkg::KIND_W-1:0]         req_event_kind,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [selbc_pkg::STATUS_W-1:0]       rsp_status,
   output logic [selbc_pkg::OUT_CNT_W-1:0]      rsp_match_count,
   output logic                                 rsp_close_request,
   output logic [selbc_pkg::OUT_CNT_W-1:0]      rsp_total_violations,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [selbc_pkg::THRESH_W-1:0]       csr_wr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_APPEND = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   // Control state
   logic [2:0]                          state_ff, state_in;
   logic [selbc_pkg::IDX_W-1:0]         wp_ff, wp_in;
   logic [selbc_pkg::CNT_W-1:0]         valid_ff, valid_in;
   logic [selbc_pkg::CNT_W-1:0]         total_ff, total_in;
   logic [selbc_pkg::THRESH_W-1:0]      thresh_ff, thresh_in;
   logic [selbc_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [selbc_pkg::CNT_W-1:0]         count_ff, count_in;
   logic                                pend_ff, pend_in;
   logic                                invalid_ff, invalid_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // Latched request payload
   logic                                log_ff, log_in;
   logic [selbc_pkg::ADDR_WIDTH-1:0]    key_ff, key_in;
   logic [selbc_pkg::ADDR_WIDTH-1:0]    remote_ff, remote_in;
   logic                                viol_ff, viol_in;

   // Result register
   logic [selbc_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic [selbc_pkg::OUT_CNT_W-1:0]     match_ff, match_in;
   logic                                close_ff, close_in;
   logic [selbc_pkg::OUT_CNT_W-1:0]     rtotal_ff, rtotal_in;

   // Log memory port
   logic                                ram_wr_en;
   logic [selbc_pkg::IDX_W-1:0]         ram_wr_addr;
   selbc_pkg::entry_type                ram_wr_entry;
   logic                                ram_rd_en;
   logic [selbc_pkg::IDX_W-1:0]         ram_rd_addr;
   logic [selbc_pkg::ENTRY_W-1:0]       ram_rd_data;
   selbc_pkg::entry_type                rd_entry;

   logic                                accept;
   logic                                full;
   logic                                hit;
   logic                                reached;
   logic                                rsp_free;

   selbc_ram #(
      .WIDTH (selbc_pkg::ENTRY_W),
      .DEPTH (selbc_pkg::LOG_DEPTH)
   ) u_log (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry  = selbc_pkg::entry_type'(ram_rd_data);
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (valid_ff == selbc_pkg::CNT_W'(selbc_pkg::LOG_DEPTH));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // A scanned entry counts when it is a violation that names the key on either side
   assign hit = pend_ff && rd_entry.viol &&
                ((rd_entry.src == key_ff) || (rd_entry.dst == key_ff));

   assign reached = (selbc_pkg::SAT_W'(count_ff) >= selbc_pkg::SAT_W'(thresh_ff));

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      valid_in     = valid_ff;
      total_in     = total_ff;
      thresh_in    = csr_wr_en ? csr_wr_data : thresh_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      pend_in      = 1'b0;
      invalid_in   = invalid_ff;
      rsp_valid_in = rsp_valid_ff;
      log_in       = log_ff;
      key_in       = key_ff;
      remote_in    = remote_ff;
      viol_in      = viol_ff;
      status_in    = status_ff;
      match_in     = match_ff;
      close_in     = close_ff;
      rtotal_in    = rtotal_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wp_ff;
      ram_wr_entry = '{viol: viol_ff, dst: remote_ff, src: key_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff;

      // Drop the result once the sink takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Count the entry read in the previous cycle
      if (hit) begin
         count_in = count_ff + selbc_pkg::CNT_W'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               log_in     = (req_mode == selbc_pkg::MODE_LOG);
               key_in     = selbc_pkg::to_key(req_local_addr);
               remote_in  = selbc_pkg::to_key(req_remote_addr);
               viol_in    = (req_event_kind inside {selbc_pkg::EV_VIOLATION,
                                                    selbc_pkg::EV_INTRUSION,
                                                    selbc_pkg::EV_ANOMALY});
               invalid_in = 1'b0;
               idx_in     = '0;
               count_in   = '0;
               if (req_mode == selbc_pkg::MODE_LOG) begin
                  if (req_event_kind == selbc_pkg::EV_NONE) begin
                     invalid_in = 1'b1;
                     state_in   = S_DONE;
                  end else begin
                     // Fetch the entry about to be overwritten
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = wp_ff;
                     state_in    = S_APPEND;
                  end
               end else if (valid_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_APPEND: begin
            ram_wr_en = 1'b1;
            if (full) begin
               total_in = total_ff
                        - selbc_pkg::CNT_W'(rd_entry.viol && (total_ff != '0))
                        + selbc_pkg::CNT_W'(viol_ff);
            end else begin
               valid_in = valid_ff + selbc_pkg::CNT_W'(1);
               total_in = total_ff + selbc_pkg::CNT_W'(viol_ff);
            end
            wp_in    = (wp_ff == selbc_pkg::IDX_W'(selbc_pkg::LOG_DEPTH - 1))
                     ? '0 : wp_ff + selbc_pkg::IDX_W'(1);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_ff;
            pend_in     = 1'b1;
            if (selbc_pkg::CNT_W'(idx_ff) == valid_ff - selbc_pkg::CNT_W'(1)) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + selbc_pkg::IDX_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hold here until the result register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (invalid_ff) begin
                  status_in = selbc_pkg::ST_INVALID;
               end else if (reached) begin
                  status_in = selbc_pkg::ST_THRESHOLD;
               end else begin
                  status_in = selbc_pkg::ST_OK;
               end
               match_in  = invalid_ff ? '0 : selbc_pkg::sat_count(count_ff);
               close_in  = !invalid_ff && reached && log_ff;
               rtotal_in = selbc_pkg::sat_count(total_ff);
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         valid_ff     <= '0;
         total_ff     <= '0;
         thresh_ff    <= selbc_pkg::THRESH_RESET;
         idx_ff       <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         invalid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         thresh_ff    <= thresh_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         invalid_ff   <= invalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      log_ff    <= log_in;
      key_ff    <= key_in;
      remote_ff <= remote_in;
      viol_ff   <= viol_in;
      status_ff <= status_in;
      match_ff  <= match_in;
      close_ff  <= close_in;
      rtotal_ff <= rtotal_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_match_count      = match_ff;
   assign rsp_close_request    = close_ff;
   assign rsp_total_violations = rtotal_ff;

endmodule

// ===== hdl/selbc_checker.sv =====
// Port-level checker for the security event log blacklist check, and its bind.
// Depends on selbc_pkg.
module selbc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [selbc_pkg::STATUS_W-1:0]     rsp_status,
   input logic [selbc_pkg::OUT_CNT_W-1:0]    rsp_match_count,
   input logic                               rsp_close_request,
   input logic [selbc_pkg::OUT_CNT_W-1:0]    rsp_total_violations
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_match_count) && $stable(rsp_close_request) &&
      $stable(rsp_total_violations))
      else $error("result beat changed under stall");

   // The block works on one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in progress");

   // A close request only comes with a reached threshold
   a_close_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_close_request |-> rsp_status == selbc_pkg::ST_THRESHOLD)
      else $error("close request without threshold status");

   // A rejected event carries no match and no close
   a_invalid_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == selbc_pkg::ST_INVALID |->
      rsp_match_count == '0 && !rsp_close_request)
      else $error("rejected event reports a match or close");

endmodule

bind security_event_log_blacklist_check selbc_checker u_selbc_checker (.*);

// ===== verif/security_event_log_blacklist_check_test.sv =====
// Testbench for security_event_log_blacklist_check: directed and random event beats,
// with a local model of the event log that predicts every response beat.
// Depends on selbc_pkg and the RTL top level; stands alone otherwise.
`timescale 1ns / 100ps

module security_event_log_blacklist_check_test;

   // Kinds above "other" carry no name in the package; they log as plain events
   localparam logic [selbc_pkg::KIND_W-1:0] EV_RESERVED_LO = 3'd5;
   localparam logic [selbc_pkg::KIND_W-1:0] EV_RESERVED_HI = 3'd7;

   localparam int ADDR_POOL_SIZE = 8;
   localparam int MAX_REPORTS    = 10;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 1100;

   // One response beat as the block reports it
   typedef struct packed {
      logic [selbc_pkg::STATUS_W-1:0]  status;
      logic [selbc_pkg::OUT_CNT_W-1:0] match_count;
      logic                            close_request;
      logic [selbc_pkg::OUT_CNT_W-1:0] total_violations;
   } verdict_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic                              req_mode;
   logic [selbc_pkg::PORT_ADDR_W-1:0] req_local_addr;
   logic [selbc_pkg::PORT_ADDR_W-1:0] req_remote_addr;
   logic [selbc_pkg::KIND_W-1:0]      req_event_kind;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [selbc_pkg::STATUS_W-1:0]    rsp_status;
   logic [selbc_pkg::OUT_CNT_W-1:0]   rsp_match_count;
   logic                              rsp_close_request;
   logic [selbc_pkg::OUT_CNT_W-1:0]   rsp_total_violations;
   logic                              csr_wr_en;
   logic [selbc_pkg::THRESH_W-1:0]    csr_wr_data;

   security_event_log_blacklist_check uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_local_addr       (req_local_addr),
      .req_remote_addr      (req_remote_addr),
      .req_event_kind       (req_event_kind),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_match_count      (rsp_match_count),
      .rsp_close_request    (rsp_close_request),
      .rsp_total_violations (rsp_total_violations),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   // Mirror of the event log: entries, write pointer, fill level and running
   // violation total, plus the threshold register as last written.
   logic [selbc_pkg::ADDR_WIDTH-1:0] shadow_src  [selbc_pkg::LOG_DEPTH];
   logic [selbc_pkg::ADDR_WIDTH-1:0] shadow_dst  [selbc_pkg::LOG_DEPTH];
   logic                             shadow_viol [selbc_pkg::LOG_DEPTH];
   int                               shadow_wr_ptr;
   int                               shadow_fill;
   int                               shadow_viol_total;
   logic [selbc_pkg::THRESH_W-1:0]   shadow_threshold;

   verdict_type                      pending_verdicts[$];
   int                               mismatches;

   // Idle control: steady_flow removes all gaps and stalls for a stretch
   bit                                steady_flow;
   logic [selbc_pkg::PORT_ADDR_W-1:0] addr_pool [ADDR_POOL_SIZE];
   int                                addr_pool_used;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Append the event (log mode, any kind but none), then scan the log for violation
   // entries that touch the local address and compare against the threshold.
   function automatic verdict_type log_and_screen(
      input logic                              mode,
      input logic [selbc_pkg::PORT_ADDR_W-1:0] local_a,
      input logic [selbc_pkg::PORT_ADDR_W-1:0] remote_a,
      input logic [selbc_pkg::KIND_W-1:0]      kind);
      verdict_type                      v;
      logic [selbc_pkg::ADDR_WIDTH-1:0] key;
      logic                             is_viol;
      logic                             reached;
      int                               hits;
      v       = '0;
      key     = selbc_pkg::ADDR_WIDTH'(local_a);
      is_viol = (kind >= selbc_pkg::EV_VIOLATION) && (kind <= selbc_pkg::EV_ANOMALY);
      if (mode == selbc_pkg::MODE_LOG) begin
         // Kind none is refused: nothing logged, no scan
         if (kind == selbc_pkg::EV_NONE) begin
            v.status           = selbc_pkg::ST_INVALID;
            v.total_violations = selbc_pkg::OUT_CNT_W'(shadow_viol_total);
            return v;
         end
         // Full log: the oldest entry is overwritten and leaves the total
         if (shadow_fill == selbc_pkg::LOG_DEPTH) begin
            if (shadow_viol[shadow_wr_ptr]) shadow_viol_total--;
         end else begin
            shadow_fill++;
         end
         shadow_src[shadow_wr_ptr]  = key;
         shadow_dst[shadow_wr_ptr]  = selbc_pkg::ADDR_WIDTH'(remote_a);
         shadow_viol[shadow_wr_ptr] = is_viol;
         if (is_viol) shadow_viol_total++;
         shadow_wr_ptr = (shadow_wr_ptr + 1) % selbc_pkg::LOG_DEPTH;
      end
      hits = 0;
      for (int i = 0; i < shadow_fill; i++) begin
         if (shadow_viol[i] && (shadow_src[i] == key || shadow_dst[i] == key)) hits++;
      end
      reached            = hits >= int'(shadow_threshold);
      v.status           = reached ? selbc_pkg::ST_THRESHOLD : selbc_pkg::ST_OK;
      v.match_count      = selbc_pkg::OUT_CNT_W'(hits);
      v.close_request    = reached && (mode == selbc_pkg::MODE_LOG);
      v.total_violations = selbc_pkg::OUT_CNT_W'(shadow_viol_total);
      return v;
   endfunction

   task automatic note_mismatch(input string what, input verdict_type want,
                                input verdict_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t: %s: expected status %0d match %0d close %0d total %0d",
                  $realtime, what, want.status, want.match_count, want.close_request,
                  want.total_violations);
         $display("%0t: %s: got      status %0d match %0d close %0d total %0d",
                  $realtime, what, got.status, got.match_count, got.close_request,
                  got.total_violations);
      end
   endtask

   // Check every response beat against the oldest prediction
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_match_count, rsp_close_request, rsp_total_violations};
         if (pending_verdicts.size() == 0) begin
            note_mismatch("unexpected response beat", '0, got);
         end else begin
            want = pending_verdicts.pop_front();
            if (got !== want) note_mismatch("response mismatch", want, got);
         end
      end
   end

   // Response stall: per beat, hold stall for a random count of cycles, either
   // right away or only once a finished beat is waiting on the port.
   initial begin
      int  hold;
      bit  late;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         hold = steady_flow ? 0 : $urandom_range(0, 13);
         late = $urandom_range(0, 1);
         if (hold != 0) begin
            rsp_stall = 1'b1;
            if (late) begin
               do @(posedge clock); while (!rsp_valid);
               @(negedge clock);
            end
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Send one request beat after a random gap; record its prediction on acceptance,
   // then drop valid at the next falling edge.
   task automatic send_beat(input logic mode,
                            input logic [selbc_pkg::PORT_ADDR_W-1:0] local_a,
                            input logic [selbc_pkg::PORT_ADDR_W-1:0] remote_a,
                            input logic [selbc_pkg::KIND_W-1:0] kind);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_mode        = mode;
      req_local_addr  = local_a;
      req_remote_addr = remote_a;
      req_event_kind  = kind;
      do @(posedge clock); while (req_stall);
      pending_verdicts.push_back(log_and_screen(mode, local_a, remote_a, kind));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Drop valid and hold off until every predicted beat has come back
   task automatic settle_log();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_threshold(input logic [selbc_pkg::THRESH_W-1:0] value);
      settle_log();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en        = 1'b0;
      shadow_threshold = value;
   endtask

   // Mostly addresses from a small pool so that scans find matches
   function automatic logic [selbc_pkg::PORT_ADDR_W-1:0] pick_addr();
      if ($urandom_range(0, 9) < 7) begin
         return addr_pool[$urandom_range(0, addr_pool_used - 1)];
      end
      return $urandom;
   endfunction

   task automatic send_random_beat(input int log_pct, input int viol_pct);
      logic                         mode;
      logic [selbc_pkg::KIND_W-1:0] kind;
      mode = ($urandom_range(0, 99) < log_pct) ? selbc_pkg::MODE_LOG : selbc_pkg::MODE_CHECK;
      if ($urandom_range(0, 99) < viol_pct) begin
         kind = selbc_pkg::KIND_W'($urandom_range(selbc_pkg::EV_VIOLATION,
                                                  selbc_pkg::EV_ANOMALY));
      end else begin
         kind = selbc_pkg::KIND_W'($urandom_range(0, 7));
      end
      send_beat(mode, pick_addr(), pick_addr(), kind);
   endtask

   // Empty log, the refused kind, each named kind, matches via source and destination,
   // and the threshold being reached at the default setting.
   task automatic test_directed_basics();
      logic [selbc_pkg::PORT_ADDR_W-1:0] host_a;
      logic [selbc_pkg::PORT_ADDR_W-1:0] host_b;
      host_a = addr_pool[2];
      host_b = addr_pool[3];
      // scan of an empty log
      send_beat(selbc_pkg::MODE_CHECK, '0, '0, selbc_pkg::EV_NONE);
      // refused, nothing logged
      send_beat(selbc_pkg::MODE_LOG, host_a, host_b, selbc_pkg::EV_NONE);
      send_beat(selbc_pkg::MODE_LOG, host_a, host_b, selbc_pkg::EV_VIOLATION);
      // match through destination
      send_beat(selbc_pkg::MODE_LOG, host_b, host_a, selbc_pkg::EV_INTRUSION);
      send_beat(selbc_pkg::MODE_LOG, host_a, host_b, selbc_pkg::EV_ANOMALY);
      // not a violation
      send_beat(selbc_pkg::MODE_LOG, host_a, host_a, selbc_pkg::EV_OTHER);
      // reserved kinds log like other
      send_beat(selbc_pkg::MODE_LOG, host_a, host_b, EV_RESERVED_LO);
      send_beat(selbc_pkg::MODE_LOG, host_a, host_b, EV_RESERVED_HI);
      // address extremes
      send_beat(selbc_pkg::MODE_LOG, '1, '0, selbc_pkg::EV_VIOLATION);
      send_beat(selbc_pkg::MODE_LOG, '0, '1, selbc_pkg::EV_VIOLATION);
      // kind ignored when checking
      send_beat(selbc_pkg::MODE_CHECK, host_a, host_b, selbc_pkg::EV_NONE);
      send_beat(selbc_pkg::MODE_CHECK, '1, '0, selbc_pkg::EV_ANOMALY);
      // both sides match, counted once
      send_beat(selbc_pkg::MODE_LOG, host_a, host_a, selbc_pkg::EV_VIOLATION);
      // reaches five: close
      send_beat(selbc_pkg::MODE_LOG, host_a, host_b, selbc_pkg::EV_INTRUSION);
      send_beat(selbc_pkg::MODE_LOG, host_b, host_a, selbc_pkg::EV_ANOMALY);
      // reached but no close
      send_beat(selbc_pkg::MODE_CHECK, host_a, host_b, selbc_pkg::EV_VIOLATION);
      // refused, total unchanged
      send_beat(selbc_pkg::MODE_LOG, host_a, host_b, selbc_pkg::EV_NONE);
   endtask

   task automatic test_threshold_extremes();
      // every scan reaches zero
      set_threshold('0);
      send_beat(selbc_pkg::MODE_CHECK, $urandom, $urandom, selbc_pkg::EV_OTHER);
      send_beat(selbc_pkg::MODE_LOG, addr_pool[3], addr_pool[4], selbc_pkg::EV_OTHER);
      send_beat(selbc_pkg::MODE_LOG, addr_pool[3], addr_pool[4], selbc_pkg::EV_NONE);
      set_threshold(selbc_pkg::THRESH_W'(1));
      send_beat(selbc_pkg::MODE_LOG, addr_pool[3], addr_pool[4], selbc_pkg::EV_VIOLATION);
      send_beat(selbc_pkg::MODE_CHECK, addr_pool[4], '0, selbc_pkg::EV_NONE);
      // out of reach
      set_threshold('1);
      send_beat(selbc_pkg::MODE_LOG, addr_pool[1], addr_pool[2], selbc_pkg::EV_VIOLATION);
      set_threshold(selbc_pkg::THRESH_W'(selbc_pkg::LOG_DEPTH));
      send_beat(selbc_pkg::MODE_CHECK, addr_pool[1], '0, selbc_pkg::EV_NONE);
   endtask

   // Four phases of mixed traffic under random thresholds; one phase runs
   // with no gaps and no stalls at all.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         set_threshold(selbc_pkg::THRESH_W'($urandom_range(1, 8)));
         steady_flow = (phase == 2);
         repeat (140) send_random_beat(80, 60);
         steady_flow = 1'b0;
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = selbc_pkg::MODE_LOG;
      req_local_addr  = '0;
      req_remote_addr = '0;
      req_event_kind  = selbc_pkg::EV_NONE;
      csr_wr_en       = 1'b0;
      csr_wr_data     = selbc_pkg::THRESH_RESET;
      mismatches      = 0;
      steady_flow     = 1'b0;
      shadow_wr_ptr     = 0;
      shadow_fill       = 0;
      shadow_viol_total = 0;
      shadow_threshold  = selbc_pkg::THRESH_RESET;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < ADDR_POOL_SIZE; i++) addr_pool[i] = $urandom;
      addr_pool_used = ADDR_POOL_SIZE;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_basics();
      test_threshold_extremes();
      test_random_traffic();

      // Drain, then allow one full scan for any stray beat
      settle_log();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run
   initial begin
      #60_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== security_event_log_blacklist_check.f =====
hdl/selbc_pkg.sv
hdl/selbc_ram.sv
hdl/security_event_log_blacklist_check.sv
hdl/selbc_checker.sv
verif/security_event_log_blacklist_check_test.sv
